// ===== sv/irfp_pkg.sv =====
// Shared types and constants for the inertial sensor reply frame parser.
// No dependencies; imported by every module of the block.
package irfp_pkg;

   localparam int unsigned NUM_WORDS = 6;
   localparam int unsigned WORD_SEL_W = 3;

   localparam logic [6:0] EULER_FRAME_BYTES = 7'd31;
   localparam logic [6:0] MIN_FRAME_BYTES = 7'd3;
   localparam logic [6:0] LEN_RESET = 7'd19;
   localparam logic [6:0] WORD_FIRST = 7'd1;
   localparam logic [6:0] WORD_LAST = 7'd24;

   localparam logic [7:0] CODE_EULER = 8'hCF;
   localparam logic [7:0] CODE_BIAS = 8'hCD;
   localparam logic [7:0] CODE_SETTINGS = 8'hDB;

   localparam logic [1:0] KIND_HUNT = 2'd0;
   localparam logic [1:0] KIND_EULER = 2'd1;
   localparam logic [1:0] KIND_BIAS = 2'd2;
   localparam logic [1:0] KIND_SETTINGS = 2'd3;

   localparam logic [2:0] ST_ATTITUDE = 3'd0;
   localparam logic [2:0] ST_BIAS_ACK = 3'd1;
   localparam logic [2:0] ST_SETTINGS_ACK = 3'd2;
   localparam logic [2:0] ST_CSUM_ERR = 3'd3;
   localparam logic [2:0] ST_NAN_REJECT = 3'd4;

   localparam logic [7:0] CSR_BIAS_LEN = 8'd0;
   localparam logic [7:0] CSR_SETTINGS_LEN = 8'd1;

   localparam logic [30:0] FLOAT_INF_MAG = 31'h7F800000;

   typedef struct packed {
      logic [2:0] status;
      logic [NUM_WORDS-1:0][31:0] words;
   } result_type;

endpackage

// ===== sv/imu_reply_frame_parser.sv =====
// Reply frame parser top level: input byte register, frame engine, result register.
// A frame's last byte is held in the input byte register, then its result is loaded into
// the result register. Throughput: one byte per cycle, set by the single-pass update of
// count, sum and word shift in irfp_engine, but stalled while a finished result waits.
// Reset: synchronous; hunting state, empty stages, both length registers 19.
module imu_reply_frame_parser (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_frame_status,
   output logic [31:0] rsp_roll_bits,
   output logic [31:0] rsp_pitch_bits,
   output logic [31:0] rsp_yaw_bits,
   output logic [31:0] rsp_rate_x_bits,
   output logic [31:0] rsp_rate_y_bits,
   output logic [31:0] rsp_rate_z_bits,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [7:0] csr_index,
   input  logic [6:0] csr_wdata
);
   import irfp_pkg::*;

   logic s1_vld_ff;
   logic [7:0] s1_byte_ff;
   logic [6:0] bias_len_ff;
   logic [6:0] settings_len_ff;
   logic s1_adv;
   logic req_xfer;
   logic frame_end;
   logic out_free;
   logic res_load;
   result_type eng_result;
   result_type out_result;

   assign csr_ready = 1'b1;
   assign s1_adv = s1_vld_ff && (!frame_end || out_free);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign req_xfer = req_valid && !req_stall;
   assign res_load = s1_adv && frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_len_ff <= LEN_RESET;
         settings_len_ff <= LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BIAS_LEN: bias_len_ff <= csr_wdata;
            CSR_SETTINGS_LEN: settings_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   irfp_engine u_engine (
      .clock(clock),
      .reset(reset),
      .advance(s1_adv),
      .rx_byte(s1_byte_ff),
      .bias_len(bias_len_ff),
      .settings_len(settings_len_ff),
      .frame_end(frame_end),
      .result(eng_result)
   );

   irfp_out_reg u_out_reg (
      .clock(clock),
      .reset(reset),
      .load(res_load),
      .result(eng_result),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .free(out_free),
      .rsp_result(out_result)
   );

   assign rsp_frame_status = out_result.status;
   assign rsp_roll_bits = out_result.words[0];
   assign rsp_pitch_bits = out_result.words[1];
   assign rsp_yaw_bits = out_result.words[2];
   assign rsp_rate_x_bits = out_result.words[3];
   assign rsp_rate_y_bits = out_result.words[4];
   assign rsp_rate_z_bits = out_result.words[5];

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(res_load && rsp_valid && rsp_stall))
      else $error("result loaded into a stalled output register");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_adv |=> s1_vld_ff && $stable(s1_byte_ff))
      else $error("held input byte lost or changed");

   a_words_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_status != ST_ATTITUDE) |->
      (rsp_roll_bits == '0) && (rsp_pitch_bits == '0) && (rsp_yaw_bits == '0) &&
      (rsp_rate_x_bits == '0) && (rsp_rate_y_bits == '0) && (rsp_rate_z_bits == '0))
      else $error("data words nonzero on a non-attitude status");
`endif

endmodule

// ===== sv/irfp_engine.sv =====
// Frame state, running checksum and float word assembly for one byte per cycle while advance is high.
// Depends on irfp_pkg.
module irfp_engine (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [7:0] rx_byte,
   input  logic [6:0] bias_len,
   input  logic [6:0] settings_len,
   output logic frame_end,
   output irfp_pkg::result_type result
);
   import irfp_pkg::*;

   logic [1:0] kind_ff, kind_in;
   logic [6:0] idx_ff, idx_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0] chk_hi_ff, chk_hi_in;
   logic [31:0] words_ff [NUM_WORDS];

   logic [6:0] len_raw;
   logic [6:0] len;
   logic [7:0] idx_p1;
   logic [7:0] idx_p2;
   logic [6:0] idx_m1;
   logic [WORD_SEL_W-1:0] word_sel;
   logic word_we;
   logic nan_any;
   logic csum_bad;

   assign idx_p1 = {1'b0, idx_ff} + 8'd1;
   assign idx_p2 = {1'b0, idx_ff} + 8'd2;
   assign idx_m1 = idx_ff - WORD_FIRST;
   assign word_sel = idx_m1[4:2];

   always_comb begin
      unique case (kind_ff)
         KIND_EULER: len_raw = EULER_FRAME_BYTES;
         KIND_BIAS: len_raw = bias_len;
         default: len_raw = settings_len;
      endcase
      len = (len_raw < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES : len_raw;
   end

   always_comb begin
      kind_in = kind_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      chk_hi_in = chk_hi_ff;
      word_we = 1'b0;
      frame_end = 1'b0;
      if (kind_ff == KIND_HUNT) begin
         unique case (rx_byte)
            CODE_EULER: kind_in = KIND_EULER;
            CODE_BIAS: kind_in = KIND_BIAS;
            CODE_SETTINGS: kind_in = KIND_SETTINGS;
            default: kind_in = KIND_HUNT;
         endcase
         if (kind_in != KIND_HUNT) begin
            idx_in = 7'd1;
            sum_in = {8'd0, rx_byte};
         end
      end else if (idx_p1 < {1'b0, len}) begin
         if (idx_p2 == {1'b0, len}) begin
            chk_hi_in = rx_byte;
         end else begin
            sum_in = sum_ff + {8'd0, rx_byte};
            word_we = (kind_ff == KIND_EULER) && (idx_ff >= WORD_FIRST) &&
                      (idx_ff <= WORD_LAST);
         end
         idx_in = idx_p1[6:0];
      end else begin
         frame_end = 1'b1;
         kind_in = KIND_HUNT;
         idx_in = 7'd0;
         sum_in = 16'd0;
      end
   end

   always_comb begin
      nan_any = 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         if (words_ff[i][30:0] > FLOAT_INF_MAG) begin
            nan_any = 1'b1;
         end
      end
      csum_bad = {chk_hi_ff, rx_byte} != sum_ff;
      result.words = '0;
      if (csum_bad) begin
         result.status = ST_CSUM_ERR;
      end else begin
         unique case (kind_ff)
            KIND_EULER: begin
               if (nan_any) begin
                  result.status = ST_NAN_REJECT;
               end else begin
                  result.status = ST_ATTITUDE;
                  for (int i = 0; i < NUM_WORDS; i++) begin
                     result.words[i] = words_ff[i];
                  end
               end
            end
            KIND_BIAS: result.status = ST_BIAS_ACK;
            default: result.status = ST_SETTINGS_ACK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_HUNT;
         idx_ff <= 7'd0;
         sum_ff <= 16'd0;
         chk_hi_ff <= 8'd0;
      end else if (advance) begin
         kind_ff <= kind_in;
         idx_ff <= idx_in;
         sum_ff <= sum_in;
         chk_hi_ff <= chk_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         if (advance && word_we && (word_sel == WORD_SEL_W'(i))) begin
            words_ff[i] <= {words_ff[i][23:0], rx_byte};
         end
      end
   end

endmodule

// ===== sv/irfp_out_reg.sv =====
// Result register between the frame engine and the response channel.
// Depends on irfp_pkg.
module irfp_out_reg (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  irfp_pkg::result_type result,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic free,
   output irfp_pkg::result_type rsp_result
);
   import irfp_pkg::*;

   logic vld_ff;
   result_type res_ff;

   assign free = !vld_ff || !rsp_stall;
   assign rsp_valid = vld_ff;
   assign rsp_result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (free) begin
         vld_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         res_ff <= result;
      end
   end

endmodule
